// ===== rtl/mf3_pkg.sv =====
// Shared constants, types and sorting-network functions for the 3x3 median filter.
package mf3_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;

    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int LW_W      = 10;
    localparam int FH_W      = 13;
    localparam int WIN_SIZE  = 9;
    localparam int MID_INDEX = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_reg_e;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [WIN_SIZE-1:0][PIX_W-1:0] win_t;

    typedef struct packed {
        win_t              win;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              frame_end;
    } job_t;

    typedef struct packed {
        pix_t              median;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              frame_end;
    } res_t;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_stat_t;

    function automatic win_t cmp_swap(input win_t p, input logic [3:0] a, input logic [3:0] b);
        win_t q;
        q = p;
        if (p[a] > p[b])
        begin
            q[a] = p[b];
            q[b] = p[a];
        end
        return q;
    endfunction

    function automatic win_t sort_layers_a(input win_t p);
        win_t q;
        q = p;
        q = cmp_swap(q, 4'd1, 4'd2);
        q = cmp_swap(q, 4'd4, 4'd5);
        q = cmp_swap(q, 4'd7, 4'd8);
        q = cmp_swap(q, 4'd0, 4'd1);
        q = cmp_swap(q, 4'd3, 4'd4);
        q = cmp_swap(q, 4'd6, 4'd7);
        q = cmp_swap(q, 4'd1, 4'd2);
        q = cmp_swap(q, 4'd4, 4'd5);
        q = cmp_swap(q, 4'd7, 4'd8);
        return q;
    endfunction

    function automatic win_t sort_layers_b(input win_t p);
        win_t q;
        q = p;
        q = cmp_swap(q, 4'd0, 4'd3);
        q = cmp_swap(q, 4'd5, 4'd8);
        q = cmp_swap(q, 4'd4, 4'd7);
        q = cmp_swap(q, 4'd3, 4'd6);
        q = cmp_swap(q, 4'd1, 4'd4);
        q = cmp_swap(q, 4'd2, 4'd5);
        q = cmp_swap(q, 4'd4, 4'd7);
        return q;
    endfunction

    function automatic win_t sort_layers_c(input win_t p);
        win_t q;
        q = p;
        q = cmp_swap(q, 4'd4, 4'd2);
        q = cmp_swap(q, 4'd6, 4'd4);
        q = cmp_swap(q, 4'd4, 4'd2);
        return q;
    endfunction

endpackage

// ===== rtl/median_filter_3x3.sv =====
// Top level of the streaming 3x3 median filter.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  pixels   | push / full               | pixel
//  results  | empty / pop               | median, center_row, center_col, frame_end
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One pixel per clock sustained while full stays low; the line store takes one read and one write per cycle.
// A window's result passes through the input registers, job queue, sort stages and result queue.
// Reset clears counters and queues; line store contents stay undefined until written.
// A stalled result side fills the result queue, then the job queue, then raises full.
module median_filter_3x3 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [mf3_pkg::PIX_W-1:0]     pixel,
    output logic                          empty,
    input  logic                          pop,
    output logic [mf3_pkg::PIX_W-1:0]     median,
    output logic [mf3_pkg::ROW_W-1:0]     center_row,
    output logic [mf3_pkg::COL_W-1:0]     center_col,
    output logic                          frame_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mf3_pkg::CFG_DAT_W-1:0] cfg_data
);

    mf3_pkg::q_stat_t q_stat;
    mf3_pkg::job_t    q_job;
    mf3_pkg::job_t    q_head;
    logic             q_push;
    logic             q_pop;

    mf3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    mf3_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_job  (q_job),
        .q_pop  (q_pop),
        .q_head (q_head),
        .q_stat (q_stat)
    );

    mf3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .median     (median),
        .center_row (center_row),
        .center_col (center_col),
        .frame_end  (frame_end)
    );

endmodule

// ===== rtl/mf3_front.sv =====
// Front end: configuration, position counters, line store, window and job classification.
module mf3_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  mf3_pkg::pix_t                 pixel,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mf3_pkg::CFG_DAT_W-1:0] cfg_data,
    input  mf3_pkg::q_stat_t              q_stat,
    output logic                          q_push,
    output mf3_pkg::job_t                 q_job
);

    logic [mf3_pkg::LW_W-1:0]  width_reg;
    logic [mf3_pkg::FH_W-1:0]  height_reg;
    logic [mf3_pkg::COL_W-1:0] col_reg;
    logic [mf3_pkg::ROW_W-1:0] row_reg;

    logic                      s1_valid_reg;
    logic                      s1_emit_reg;
    logic                      s1_end_reg;
    mf3_pkg::pix_t             s1_pixel_reg;
    logic [mf3_pkg::COL_W-1:0] s1_addr_reg;
    logic [mf3_pkg::ROW_W-1:0] s1_row_reg;
    logic [mf3_pkg::COL_W-1:0] s1_col_reg;

    logic [2*mf3_pkg::PIX_W-1:0] line_mem [mf3_pkg::MAX_WIDTH];
    logic [2*mf3_pkg::PIX_W-1:0] mem_rd_reg;

    mf3_pkg::win_t             win_reg;
    mf3_pkg::win_t             win_next;

    logic                      accept;
    logic [mf3_pkg::LW_W-1:0]  width_eff;
    logic [mf3_pkg::FH_W-1:0]  height_eff;
    logic                      last_col;
    logic                      last_row;
    logic                      emit;
    logic [mf3_pkg::Q_CNT_W:0] pending;
    mf3_pkg::pix_t             top_pix;
    mf3_pkg::pix_t             mid_pix;

    assign cfg_ready = 1'b1;

    assign pending = {1'b0, q_stat.count} + {{mf3_pkg::Q_CNT_W{1'b0}}, s1_valid_reg};
    assign full    = (pending >= (mf3_pkg::Q_CNT_W + 1)'(mf3_pkg::Q_DEPTH));
    assign accept  = push & ~full;

    always_comb
    begin
        if (width_reg < mf3_pkg::LW_W'(mf3_pkg::MIN_DIM))
            width_eff = mf3_pkg::LW_W'(mf3_pkg::MIN_DIM);
        else if (width_reg > mf3_pkg::LW_W'(mf3_pkg::MAX_WIDTH))
            width_eff = mf3_pkg::LW_W'(mf3_pkg::MAX_WIDTH);
        else
            width_eff = width_reg;

        if (height_reg < mf3_pkg::FH_W'(mf3_pkg::MIN_DIM))
            height_eff = mf3_pkg::FH_W'(mf3_pkg::MIN_DIM);
        else if (height_reg > mf3_pkg::FH_W'(mf3_pkg::MAX_HEIGHT))
            height_eff = mf3_pkg::FH_W'(mf3_pkg::MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    assign last_col = (mf3_pkg::LW_W'(col_reg) + mf3_pkg::LW_W'(1)) >= width_eff;
    assign last_row = (mf3_pkg::FH_W'(row_reg) + mf3_pkg::FH_W'(1)) >= height_eff;
    assign emit     = (col_reg >= mf3_pkg::COL_W'(2)) && (row_reg >= mf3_pkg::ROW_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mf3_pkg::LW_W'(mf3_pkg::MAX_WIDTH);
            height_reg <= mf3_pkg::FH_W'(512);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mf3_pkg::CFG_LINE_WIDTH:   width_reg  <= cfg_data[mf3_pkg::LW_W-1:0];
                mf3_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance position counters on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + mf3_pkg::ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + mf3_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_addr_reg  <= col_reg;
            s1_emit_reg  <= emit;
            s1_end_reg   <= last_col & last_row;
            s1_row_reg   <= row_reg - mf3_pkg::ROW_W'(1);
            s1_col_reg   <= col_reg - mf3_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            mem_rd_reg <= line_mem[col_reg];
        if (s1_valid_reg)
            line_mem[s1_addr_reg] <= {mem_rd_reg[mf3_pkg::PIX_W-1:0], s1_pixel_reg};
    end

    assign top_pix = mem_rd_reg[2*mf3_pkg::PIX_W-1:mf3_pkg::PIX_W];
    assign mid_pix = mem_rd_reg[mf3_pkg::PIX_W-1:0];

    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = top_pix;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid_pix;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_pixel_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            win_reg <= win_next;
    end

    assign q_push          = s1_valid_reg & s1_emit_reg;
    assign q_job.win       = win_next;
    assign q_job.row       = s1_row_reg;
    assign q_job.col       = s1_col_reg;
    assign q_job.frame_end = s1_end_reg;

endmodule

// ===== rtl/mf3_queue.sv =====
// Short job queue between the front end and the sorting back end.
module mf3_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_push,
    input  mf3_pkg::job_t    q_job,
    input  logic             q_pop,
    output mf3_pkg::job_t    q_head,
    output mf3_pkg::q_stat_t q_stat
);

    mf3_pkg::job_t                entry_reg [mf3_pkg::Q_DEPTH];
    logic [mf3_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [mf3_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [mf3_pkg::Q_CNT_W-1:0]  count_reg;
    logic                         do_pop;

    assign do_pop       = q_pop & (count_reg != '0);
    assign q_head       = entry_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push)
                wr_ptr_reg <= wr_ptr_reg + mf3_pkg::Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + mf3_pkg::Q_PTR_W'(1);
            if (q_push && !do_pop)
                count_reg <= count_reg + mf3_pkg::Q_CNT_W'(1);
            else if (!q_push && do_pop)
                count_reg <= count_reg - mf3_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            entry_reg[wr_ptr_reg] <= q_job;
    end

endmodule

// ===== rtl/mf3_back.sv =====
// Back end: pipelined compare-exchange network and result queue.
module mf3_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mf3_pkg::job_t             q_head,
    input  mf3_pkg::q_stat_t          q_stat,
    output logic                      q_pop,
    output logic                      empty,
    input  logic                      pop,
    output mf3_pkg::pix_t             median,
    output logic [mf3_pkg::ROW_W-1:0] center_row,
    output logic [mf3_pkg::COL_W-1:0] center_col,
    output logic                      frame_end
);

    logic                           v1_reg;
    logic                           v2_reg;
    logic                           v3_reg;
    mf3_pkg::job_t                  st1_reg;
    mf3_pkg::job_t                  st2_reg;
    mf3_pkg::res_t                  st3_reg;
    mf3_pkg::win_t                  sorted_c;

    mf3_pkg::res_t                  out_reg [mf3_pkg::OUT_DEPTH];
    logic [mf3_pkg::OUT_PTR_W-1:0]  out_wr_reg;
    logic [mf3_pkg::OUT_PTR_W-1:0]  out_rd_reg;
    logic [mf3_pkg::OUT_CNT_W-1:0]  out_cnt_reg;
    logic [mf3_pkg::OUT_CNT_W:0]    in_flight;
    logic                           out_pop;
    mf3_pkg::res_t                  head;

    assign in_flight = {1'b0, out_cnt_reg}
                     + (mf3_pkg::OUT_CNT_W + 1)'(v1_reg)
                     + (mf3_pkg::OUT_CNT_W + 1)'(v2_reg)
                     + (mf3_pkg::OUT_CNT_W + 1)'(v3_reg);
    assign q_pop     = ~q_stat.empty &&
                       (in_flight < (mf3_pkg::OUT_CNT_W + 1)'(mf3_pkg::OUT_DEPTH));

    assign sorted_c = mf3_pkg::sort_layers_c(st2_reg.win);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= q_pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_reg.win       <= mf3_pkg::sort_layers_a(q_head.win);
        st1_reg.row       <= q_head.row;
        st1_reg.col       <= q_head.col;
        st1_reg.frame_end <= q_head.frame_end;
        st2_reg.win       <= mf3_pkg::sort_layers_b(st1_reg.win);
        st2_reg.row       <= st1_reg.row;
        st2_reg.col       <= st1_reg.col;
        st2_reg.frame_end <= st1_reg.frame_end;
        st3_reg.median    <= sorted_c[mf3_pkg::MID_INDEX];
        st3_reg.row       <= st2_reg.row;
        st3_reg.col       <= st2_reg.col;
        st3_reg.frame_end <= st2_reg.frame_end;
    end

    assign empty   = (out_cnt_reg == '0);
    assign out_pop = pop & ~empty;
    assign head    = out_reg[out_rd_reg];

    assign median     = head.median;
    assign center_row = head.row;
    assign center_col = head.col;
    assign frame_end  = head.frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg  <= '0;
            out_rd_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (v3_reg)
                out_wr_reg <= out_wr_reg + mf3_pkg::OUT_PTR_W'(1);
            if (out_pop)
                out_rd_reg <= out_rd_reg + mf3_pkg::OUT_PTR_W'(1);
            if (v3_reg && !out_pop)
                out_cnt_reg <= out_cnt_reg + mf3_pkg::OUT_CNT_W'(1);
            else if (!v3_reg && out_pop)
                out_cnt_reg <= out_cnt_reg - mf3_pkg::OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg)
            out_reg[out_wr_reg] <= st3_reg;
    end

endmodule

// ===== rtl/mf3_checker.sv =====
// Port-level checks for the median filter, bound to the top level.
module mf3_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      empty,
    input  logic                      pop,
    input  logic [mf3_pkg::PIX_W-1:0] median,
    input  logic [mf3_pkg::ROW_W-1:0] center_row,
    input  logic [mf3_pkg::COL_W-1:0] center_col,
    input  logic                      frame_end
);

    a_empty_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(median) && $stable(center_row)
                           && $stable(center_col) && $stable(frame_end))
        else $error("stalled result changed");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (center_row != '0) && (center_col != '0))
        else $error("border position on result port");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .median     (median),
    .center_row (center_row),
    .center_col (center_col),
    .frame_end  (frame_end)
);
